/* rtl/core/sdobdc_pkg.sv */
package sdobdc_pkg;

  // Default sizes of the image store and of one SDO block.
  localparam int IMAGE_BYTES_DEF = 65536;
  localparam int BLOCK_BYTES_DEF = 256;
  localparam int Q_DEPTH = 4;

  // Field widths fixed by the interface.
  localparam int POS_W = 17;
  localparam int N_W = 10;
  localparam int SEQ_W = 7;

  // Input operations.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Result events.
  localparam logic [1:0] EV_FRAME    = 2'd0;
  localparam logic [1:0] EV_COMPLETE = 2'd1;
  localparam logic [1:0] EV_TIMEOUT  = 2'd2;
  localparam logic [1:0] EV_FAILED   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_NODE_ID      = 2'd0;
  localparam logic [1:0] REG_IMAGE_LENGTH = 2'd1;
  localparam logic [1:0] REG_TIMEOUT      = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // Protocol constants.
  localparam logic [10:0] ID_HEARTBEAT = 11'h700;
  localparam logic [10:0] ID_SDO_RX    = 11'h580;
  localparam logic [10:0] ID_SDO_TX    = 11'h600;
  localparam logic [7:0]  CMD_ACK_INIT = 8'hA4;
  localparam logic [7:0]  CMD_ACK_END  = 8'hA1;
  localparam logic [7:0]  CMD_ABORT    = 8'h80;
  localparam logic [7:0]  NMT_RESET    = 8'h81;
  localparam logic [7:0]  END_CMD      = 8'hC1;
  localparam logic [63:0] INIT_DATA    = 64'h0000_0000_011F_5062;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  // Job kinds handed from the front to the back.
  localparam logic JOB_FRAME = 1'b0;
  localparam logic JOB_BLOCK = 1'b1;

  typedef struct packed {
    logic             kind;
    logic             last;
    logic [10:0]      id;
    logic [3:0]       len;
    logic [63:0]      data;
    logic [1:0]       ev;
    logic [POS_W-1:0] start;
    logic [N_W-1:0]   n;
  } job_t;

  function automatic job_t mk_frame(logic [10:0] id, logic [3:0] len, logic [63:0] data,
                                    logic [1:0] ev);
    job_t j;
    j = '0;
    j.kind = JOB_FRAME;
    j.id = id;
    j.len = len;
    j.data = data;
    j.ev = ev;
    return j;
  endfunction

  function automatic job_t mk_block(logic [POS_W-1:0] start, logic [N_W-1:0] n);
    job_t j;
    j = '0;
    j.kind = JOB_BLOCK;
    j.start = start;
    j.n = n;
    return j;
  endfunction

  // CRC-16/XMODEM update with one byte.
  function automatic logic [15:0] crc_byte(logic [15:0] c_in, logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/core/sdobdc_ram.sv */
module sdobdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/sdobdc_queue.sv */
module sdobdc_queue
  import sdobdc_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic empty,
  output logic full
);

  localparam int PW = $clog2(DEPTH);

  job_t           slots [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [PW:0]    count;

  assign empty = (count == '0);
  assign full = (count == (PW+1)'(DEPTH));
  assign pop_job = slots[rptr];

  // Entries are stored in arrival order; pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

endmodule

/* rtl/core/sdobdc_front.sv */
module sdobdc_front
  import sdobdc_pkg::*;
#(
  parameter int IMAGE_BYTES = IMAGE_BYTES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int AW = $clog2(IMAGE_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [47:0]   s_tdata,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [16:0]   cfg_data,
  input  logic          back_busy,
  input  logic          q_empty,
  input  logic          q_full,
  output logic          push,
  output job_t          push_job,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_WAIT     = 3'd1;
  localparam logic [2:0] PH_INIT     = 3'd2;
  localparam logic [2:0] PH_DOWNLOAD = 3'd3;
  localparam logic [2:0] PH_END      = 3'd4;

  // Configuration registers.
  logic [6:0]       node_id;
  logic [16:0]      image_length;
  logic [15:0]      timeout_ticks;

  // Transfer state.
  logic [2:0]       phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [POS_W-1:0] block_start, block_start_next;
  logic [15:0]      ticks_left, ticks_left_next;
  logic             echo_pending, echo_pending_next;

  // Jobs produced by the item, pushed one per cycle while the job queue is not full.
  job_t             job0, job1, job_a, job_b;
  logic [1:0]       pend, nj;

  logic [1:0]       op;
  logic [15:0]      load_address;
  logic [7:0]       load_byte;
  logic [10:0]      rx_id;
  logic [7:0]       rx_command;
  logic             accept;
  logic [10:0]      id_hb, id_sr, id_st;
  logic [63:0]      nmt_data;
  logic [POS_W-1:0] eff_len, rem;
  logic [N_W-1:0]   blk_n;
  job_t             j_list [2];

  assign op = s_tdata[1:0];
  assign load_address = s_tdata[17:2];
  assign load_byte = s_tdata[25:18];
  assign rx_id = s_tdata[36:26];
  assign rx_command = s_tdata[44:37];

  // Loads wait until all earlier store reads are finished.
  assign s_tready = (pend == 2'd0) &&
                    !(op == OP_LOAD && (back_busy || !q_empty));
  assign accept = s_tvalid && s_tready;

  assign ram_we = accept && op == OP_LOAD && phase == PH_IDLE &&
                  (32'(load_address) < 32'(IMAGE_BYTES));
  assign ram_waddr = AW'(load_address);
  assign ram_wdata = load_byte;

  assign push = (pend != 2'd0) && !q_full;
  assign push_job = job0;

  assign id_hb = ID_HEARTBEAT + {4'b0, node_id};
  assign id_sr = ID_SDO_RX + {4'b0, node_id};
  assign id_st = ID_SDO_TX + {4'b0, node_id};
  assign nmt_data = {48'b0, 1'b0, node_id, NMT_RESET};
  assign eff_len = ({15'b0, image_length} > 32'(IMAGE_BYTES)) ? POS_W'(IMAGE_BYTES)
                                                              : image_length;

  // Next state and jobs of the accepted item.
  always_comb begin
    phase_next = phase;
    byte_position_next = byte_position;
    block_start_next = block_start;
    ticks_left_next = ticks_left;
    echo_pending_next = echo_pending;
    nj = 2'd0;
    j_list[0] = '0;
    j_list[1] = '0;
    rem = '0;
    blk_n = '0;
    case (op)
      OP_LOAD: begin
      end
      OP_START: begin
        ticks_left_next = timeout_ticks;
        byte_position_next = '0;
        block_start_next = '0;
        echo_pending_next = 1'b0;
        phase_next = PH_WAIT;
        j_list[0] = mk_frame(11'd0, 4'd2, nmt_data, EV_FRAME);
        nj = 2'd1;
      end
      OP_RX: begin
        if (phase != PH_IDLE) begin
          if (rx_id == id_hb || rx_id == id_sr) begin
            ticks_left_next = timeout_ticks;
          end
          if (rx_id == id_hb && rx_command == 8'h00) begin
            byte_position_next = '0;
            block_start_next = '0;
            phase_next = PH_INIT;
          end
          if (phase_next == PH_INIT) begin
            j_list[0] = mk_frame(id_st, 4'd8, INIT_DATA, EV_FRAME);
            nj = 2'd1;
            echo_pending_next = 1'b1;
            phase_next = PH_DOWNLOAD;
          end else if (phase_next == PH_DOWNLOAD) begin
            if (rx_id == id_sr && rx_command == CMD_ACK_INIT) begin
              rem = (byte_position_next < eff_len) ? eff_len - byte_position_next : '0;
              blk_n = (32'(rem) > 32'(BLOCK_BYTES)) ? N_W'(BLOCK_BYTES) : N_W'(rem);
              block_start_next = byte_position_next;
              j_list[0] = mk_block(byte_position_next, blk_n);
              // The back sends the block's frames to this identifier.
              j_list[0].id = id_st;
              nj = 2'd1;
              byte_position_next = byte_position_next + POS_W'(blk_n);
              echo_pending_next = 1'b1;
              phase_next = PH_END;
            end
          end else if (phase_next == PH_END) begin
            if (echo_pending) begin
              echo_pending_next = 1'b0;
            end else if (rx_id == id_sr && rx_command == CMD_ABORT) begin
              phase_next = PH_INIT;
              byte_position_next = block_start_next;
              if (block_start_next == '0) begin
                phase_next = PH_IDLE;
                j_list[0] = mk_frame(11'd0, 4'd0, 64'd0, EV_FAILED);
                nj = 2'd1;
              end
            end else if (rx_id == id_sr && rx_command == CMD_ACK_END) begin
              phase_next = PH_INIT;
            end
          end
        end
      end
      default: begin
        if (phase != PH_IDLE) begin
          if (ticks_left != 16'd0) begin
            ticks_left_next = ticks_left - 1'b1;
          end else begin
            ticks_left_next = timeout_ticks;
            byte_position_next = '0;
            block_start_next = '0;
            echo_pending_next = 1'b0;
            phase_next = PH_WAIT;
            j_list[0] = mk_frame(11'd0, 4'd2, nmt_data, EV_TIMEOUT);
            nj = 2'd1;
          end
          if (phase_next == PH_INIT) begin
            j_list[nj[0]] = mk_frame(id_st, 4'd8, INIT_DATA, EV_FRAME);
            nj = nj + 1'b1;
            echo_pending_next = 1'b1;
            phase_next = PH_DOWNLOAD;
          end else if (phase_next == PH_END && echo_pending_next) begin
            echo_pending_next = 1'b0;
          end
          if (byte_position_next == eff_len) begin
            j_list[nj[0]] = mk_frame(11'd0, 4'd2, nmt_data, EV_COMPLETE);
            nj = nj + 1'b1;
            phase_next = PH_IDLE;
          end
        end
      end
    endcase
    job_a = j_list[0];
    job_b = j_list[1];
    if (nj == 2'd1) begin
      job_a.last = 1'b1;
    end
    if (nj == 2'd2) begin
      job_b.last = 1'b1;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      byte_position <= '0;
      block_start <= '0;
      ticks_left <= '0;
      echo_pending <= 1'b0;
      node_id <= '0;
      image_length <= '0;
      timeout_ticks <= TIMEOUT_RESET;
      pend <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_ID:      node_id <= cfg_data[6:0];
          REG_IMAGE_LENGTH: image_length <= cfg_data;
          REG_TIMEOUT:      timeout_ticks <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase <= phase_next;
        byte_position <= byte_position_next;
        block_start <= block_start_next;
        ticks_left <= ticks_left_next;
        echo_pending <= echo_pending_next;
        pend <= nj;
      end else if (push) begin
        pend <= pend - 1'b1;
      end
    end
  end

  // Job holding registers; the second moves up after each push.
  always_ff @(posedge clk) begin
    if (accept) begin
      job0 <= job_a;
      job1 <= job_b;
    end else if (push) begin
      job0 <= job1;
    end
  end

endmodule

/* rtl/core/sdobdc_back.sv */
module sdobdc_back
  import sdobdc_pkg::*;
#(
  parameter int AW = $clog2(IMAGE_BYTES_DEF)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  job_t          q_job,
  output logic          pop,
  output logic          busy,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [79:0]   m_tdata,
  output logic [1:0]    m_tuser,
  output logic          m_tlast
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_RD   = 3'd1;
  localparam logic [2:0] B_DAT  = 3'd2;
  localparam logic [2:0] B_SEG  = 3'd3;
  localparam logic [2:0] B_END  = 3'd4;
  localparam logic [2:0] B_FRM  = 3'd5;

  logic [2:0]       bst;
  job_t             job;
  logic [N_W-1:0]   idx;
  logic [2:0]       k;
  logic [SEQ_W-1:0] seq;
  logic [55:0]      seg;
  logic [15:0]      crc;
  logic [2:0]       unused;

  logic [10:0]      o_id;
  logic [3:0]       o_len;
  logic [63:0]      o_data;

  logic             out_free, seg_done, blk_done;
  logic [N_W-1:0]   idx_inc;
  logic [POS_W:0]   rd_pos;

  assign m_tdata = {1'b0, o_data, o_len, o_id};
  assign out_free = !m_tvalid || m_tready;
  assign busy = (bst != B_IDLE);
  assign pop = (bst == B_IDLE) && !q_empty;

  // Segment closes on its seventh byte or on the block's last byte.
  assign idx_inc = idx + 1'b1;
  assign blk_done = (idx_inc == job.n);
  assign seg_done = (k == 3'd6) || blk_done;

  // Next byte is read while the current one is folded in.
  assign ram_re = (bst == B_RD) || (bst == B_DAT && !seg_done);
  assign rd_pos = {1'b0, job.start} + (POS_W+1)'(idx) +
                  (POS_W+1)'(bst == B_DAT);
  assign ram_raddr = AW'(rd_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      bst <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (bst)
        B_IDLE: begin
          if (pop) begin
            if (q_job.kind == JOB_FRAME) begin
              bst <= B_FRM;
            end else if (q_job.n == '0) begin
              bst <= B_END;
            end else begin
              bst <= B_RD;
            end
          end
        end
        B_RD: bst <= B_DAT;
        B_DAT: begin
          if (seg_done) begin
            bst <= B_SEG;
          end
        end
        B_SEG: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            bst <= (idx == job.n) ? B_END : B_RD;
          end
        end
        B_END, B_FRM: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            bst <= B_IDLE;
          end
        end
        default: bst <= B_IDLE;
      endcase
    end
  end

  // Block walk and output payload.
  always_ff @(posedge clk) begin
    case (bst)
      B_IDLE: begin
        if (pop) begin
          job <= q_job;
          idx <= '0;
          k <= '0;
          seq <= '0;
          seg <= '0;
          crc <= '0;
          unused <= '0;
        end
      end
      B_DAT: begin
        seg[{k, 3'b000} +: 8] <= ram_rdata;
        crc <= crc_byte(crc, ram_rdata);
        idx <= idx_inc;
        k <= k + 1'b1;
      end
      B_SEG: begin
        if (out_free) begin
          o_id <= job.id;
          o_len <= 4'd8;
          o_data <= {seg, (idx == job.n), seq};
          m_tuser <= EV_FRAME;
          m_tlast <= 1'b0;
          seq <= seq + 1'b1;
          unused <= (k == 3'd7) ? 3'd0 : 3'd7 - k;
          k <= '0;
          seg <= '0;
        end
      end
      B_END: begin
        if (out_free) begin
          o_id <= job.id;
          o_len <= 4'd8;
          o_data <= {40'b0, crc, END_CMD | {3'b0, unused, 2'b00}};
          m_tuser <= EV_FRAME;
          m_tlast <= job.last;
        end
      end
      B_FRM: begin
        if (out_free) begin
          o_id <= job.id;
          o_len <= job.len;
          o_data <= job.data;
          m_tuser <= job.ev;
          m_tlast <= job.last;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/sdo_block_download_client.sv */
// Channel  | Direction | Contents
// s_*      | in        | tdata: operation, load_address, load_byte, rx_id, rx_command
// m_*      | out       | tdata: tx_id, tx_length, tx_data; tuser: event_res; tlast: last
// cfg_*    | in        | write: index 0 node_id, 1 image_length, 2 timeout_ticks
//
// The front handles a load, start, tick or plain reply and hands each frame it
// causes to the back. A block acknowledge walks the image store once through its
// single read port. Reset is synchronous and clears the control state; the image
// store holds its contents. A stalled output holds the back; the front keeps taking
// items until the job queue fills, and holds load beats until the back is done.
module sdo_block_download_client
  import sdobdc_pkg::*;
#(
  parameter int IMAGE_BYTES = IMAGE_BYTES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[1:0], load_address[17:2], load_byte[25:18], rx_id[36:26],
  // rx_command[44:37]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tx_id[10:0], tx_length[14:11], tx_data[78:15]
  output logic [79:0] m_tdata,
  // event_res[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int AW = $clog2(IMAGE_BYTES);

  logic          back_busy, q_empty, q_full, push, pop;
  job_t          push_job, pop_job;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  sdobdc_front #(
    .IMAGE_BYTES(IMAGE_BYTES),
    .BLOCK_BYTES(BLOCK_BYTES),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .back_busy(back_busy),
    .q_empty(q_empty),
    .q_full(q_full),
    .push(push),
    .push_job(push_job),
    .ram_we(ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata)
  );

  sdobdc_queue #(
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .pop(pop),
    .pop_job(pop_job),
    .empty(q_empty),
    .full(q_full)
  );

  sdobdc_ram #(
    .WIDTH(8),
    .DEPTH(IMAGE_BYTES)
  ) u_image (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sdobdc_back #(
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_job(pop_job),
    .pop(pop),
    .busy(back_busy),
    .ram_re(ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

endmodule

/* tb/sdo_block_download_client_checker.sv */
module sdo_block_download_client_checker
  import sdobdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          errors,
  output int          outstanding
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_WAIT_BOOT, ST_INIT, ST_DOWNLOAD, ST_END
  } client_phase_e;

  typedef struct packed {
    logic [10:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    logic [1:0]  ev;
    logic        last;
  } can_frame_t;

  can_frame_t    frames_due[$];
  logic [7:0]    image [0:IMAGE_BYTES_DEF-1];
  client_phase_e phase;
  logic [16:0]   byte_pos;
  logic [16:0]   blk_start;
  logic [15:0]   ticks_left;
  logic          echo_wait;
  logic [6:0]    node;
  logic [16:0]   img_len;
  logic [15:0]   tmo;
  int            mismatches;

  initial begin
    errors = 0;
    outstanding = 0;
    mismatches = 0;
  end

  function automatic int usable_length();
    return (img_len > IMAGE_BYTES_DEF) ? IMAGE_BYTES_DEF : int'(img_len);
  endfunction

  function automatic void queue_frame(logic [10:0] id, logic [3:0] len, logic [63:0] data,
                                      logic [1:0] ev);
    can_frame_t f;
    f.id = id;
    f.len = len;
    f.data = data;
    f.ev = ev;
    f.last = 1'b0;
    frames_due.push_back(f);
  endfunction

  function automatic logic [63:0] nmt_reset_data();
    return {48'h0, 1'b0, node, NMT_RESET};
  endfunction

  // Back to waiting for boot-up; sends the NMT reset frame.
  function automatic void restart_download(logic [1:0] ev);
    ticks_left = tmo;
    byte_pos = '0;
    blk_start = '0;
    echo_wait = 1'b0;
    phase = ST_WAIT_BOOT;
    queue_frame(11'h000, 4'd2, nmt_reset_data(), ev);
  endfunction

  // One step of the block transfer. Returns 1 when the server rejected the block.
  function automatic bit advance_block(bit has_rx, logic [10:0] id, logic [7:0] cmd);
    logic [10:0] tx_id;
    logic [10:0] rx_id;
    logic [63:0] d;
    logic [15:0] crc;
    int          n;
    int          off;
    int          chunk;
    int          seq;
    int          unused;
    tx_id = ID_SDO_TX + 11'(node);
    rx_id = ID_SDO_RX + 11'(node);
    case (phase)
      ST_INIT: begin
        queue_frame(tx_id, 4'd8, INIT_DATA, EV_FRAME);
        echo_wait = 1'b1;
        phase = ST_DOWNLOAD;
      end
      ST_DOWNLOAD: begin
        if (has_rx && id == rx_id && cmd == CMD_ACK_INIT) begin
          n = (int'(byte_pos) < usable_length()) ? usable_length() - int'(byte_pos) : 0;
          if (n > BLOCK_BYTES_DEF) n = BLOCK_BYTES_DEF;
          blk_start = byte_pos;
          seq = 0;
          // Seven data bytes per segment, sequence number in byte zero.
          for (off = 0; off < n; off += 7) begin
            chunk = (n - off < 7) ? n - off : 7;
            d = '0;
            for (int k = 0; k < chunk; k++)
              d[8*(k+1) +: 8] = image[int'(blk_start) + off + k];
            d[6:0] = 7'(seq);
            d[7] = (off + chunk == n);
            seq++;
            queue_frame(tx_id, 4'd8, d, EV_FRAME);
          end
          // CRC-16/XMODEM over the block's bytes.
          crc = '0;
          for (int k = 0; k < n; k++) begin
            crc = crc ^ {image[int'(blk_start) + k], 8'h00};
            for (int b = 0; b < 8; b++)
              crc = crc[15] ? ((crc << 1) ^ 16'h1021) : (crc << 1);
          end
          byte_pos = blk_start + 17'(n);
          unused = (7 - n % 7) % 7;
          queue_frame(tx_id, 4'd8, {40'h0, crc, END_CMD | 8'(unused << 2)}, EV_FRAME);
          echo_wait = 1'b1;
          phase = ST_END;
        end
      end
      ST_END: begin
        if (echo_wait) begin
          echo_wait = 1'b0;
        end else if (has_rx && id == rx_id && cmd == CMD_ABORT) begin
          phase = ST_INIT;
          return 1'b1;
        end else if (has_rx && id == rx_id && cmd == CMD_ACK_END) begin
          phase = ST_INIT;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Works out the frames that one accepted input beat causes.
  function automatic void take_beat(logic [47:0] t);
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  val;
    logic [10:0] id;
    logic [7:0]  cmd;
    logic [10:0] hb;
    int          n0;
    op = t[1:0];
    addr = t[17:2];
    val = t[25:18];
    id = t[36:26];
    cmd = t[44:37];
    n0 = frames_due.size();
    if (op == OP_LOAD) begin
      if (phase == ST_IDLE) image[addr] = val;
    end else if (op == OP_START) begin
      restart_download(EV_FRAME);
    end else if (phase != ST_IDLE) begin
      if (op == OP_RX) begin
        hb = ID_HEARTBEAT + 11'(node);
        if (id == hb || id == ID_SDO_RX + 11'(node)) ticks_left = tmo;
        if (id == hb && cmd == 8'h00) begin
          byte_pos = '0;
          blk_start = '0;
          phase = ST_INIT;
        end
        if (advance_block(1'b1, id, cmd)) begin
          byte_pos = blk_start;
          // A rejected first block stops the transfer.
          if (blk_start == 0) begin
            phase = ST_IDLE;
            queue_frame(11'h000, 4'd0, 64'h0, EV_FAILED);
          end
        end
      end else begin
        if (ticks_left > 0) ticks_left--;
        else restart_download(EV_TIMEOUT);
        void'(advance_block(1'b0, 11'h000, 8'h00));
        if (int'(byte_pos) == usable_length()) begin
          queue_frame(11'h000, 4'd2, nmt_reset_data(), EV_COMPLETE);
          phase = ST_IDLE;
        end
      end
    end
    if (frames_due.size() > n0) frames_due[frames_due.size()-1].last = 1'b1;
  endfunction

  // Prediction, register mirror and comparison of output beats.
  always @(posedge clk) begin
    can_frame_t got;
    can_frame_t want;
    if (rst) begin
      phase = ST_IDLE;
      byte_pos = '0;
      blk_start = '0;
      ticks_left = '0;
      echo_wait = 1'b0;
      node = '0;
      img_len = '0;
      tmo = TIMEOUT_RESET;
      frames_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_ID:      node = cfg_data[6:0];
          REG_IMAGE_LENGTH: img_len = cfg_data;
          REG_TIMEOUT:      tmo = cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) take_beat(s_tdata);
      if (m_tvalid && m_tready) begin
        got.id = m_tdata[10:0];
        got.len = m_tdata[14:11];
        got.data = m_tdata[78:15];
        got.ev = m_tuser;
        got.last = m_tlast;
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected output beat: id=%h len=%0d data=%h ev=%0d last=%0b",
                     got.id, got.len, got.data, got.ev, got.last);
        end else begin
          want = frames_due.pop_front();
          if (got.id !== want.id || got.len !== want.len || got.data !== want.data ||
              got.ev !== want.ev || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: id %h/%h len %0d/%0d ev %0d/%0d last %0b/%0b (exp/got)",
                       want.id, got.id, want.len, got.len, want.ev, got.ev,
                       want.last, got.last);
              $display("  data exp %h got %h", want.data, got.data);
            end
          end
        end
      end
    end
    errors <= mismatches;
    outstanding <= frames_due.size();
  end

endmodule

/* tb/sdo_block_download_client_tb.sv */
module sdo_block_download_client_tb;
  import sdobdc_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 1000;
  localparam int FILLED_BYTES = 320;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  int          errors;
  int          outstanding;
  int          cycles = 0;
  int          rx_stall = 0;
  bit          calm = 1'b0;
  logic [6:0]  cur_node = '0;

  always #5 clk = ~clk;

  sdo_block_download_client uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sdo_block_download_client_checker frame_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: after each beat it stalls for a random stretch, unless calm is set.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) rx_stall = calm ? 0 : $urandom_range(0, 16);
    else if (!m_tready && rx_stall > 0) rx_stall--;
    m_tready <= (rx_stall == 0);
  end

  // Sends one input beat after a random gap and waits for its acceptance.
  task automatic send_beat(logic [1:0] op, logic [15:0] addr, logic [7:0] val,
                           logic [10:0] id, logic [7:0] cmd);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, cmd, id, val, addr, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_rx(logic [10:0] id, logic [7:0] cmd);
    send_beat(OP_RX, 16'h0, 8'h0, id, cmd);
  endtask

  task automatic send_tick();
    send_beat(OP_TICK, 16'h0, 8'h0, 11'h0, 8'h0);
  endtask

  task automatic send_start();
    send_beat(OP_START, 16'h0, 8'h0, 11'h0, 8'h0);
  endtask

  // Holds the input until every expected frame is out, then lets the back settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_NODE_ID) cur_node = val[6:0];
  endtask

  task automatic set_config(logic [6:0] node, logic [16:0] len, logic [15:0] tmo);
    drain();
    write_reg(REG_NODE_ID, {10'h0, node});
    write_reg(REG_IMAGE_LENGTH, len);
    write_reg(REG_TIMEOUT, {1'b0, tmo});
  endtask

  // Start, boot-up, and the acknowledge of the first block; a foreign frame
  // then takes the echo of the end frame.
  task automatic open_block();
    send_start();
    send_rx(ID_HEARTBEAT + 11'(cur_node), 8'h00);
    send_rx(ID_SDO_RX + 11'(cur_node), CMD_ACK_INIT);
    send_rx(11'h123, 8'h55);
  endtask

  // Mostly protocol-shaped beats with random content, some noise.
  task automatic send_random();
    int r;
    int sel;
    logic [7:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_beat(OP_LOAD, 16'($urandom), 8'($urandom), 11'($urandom), 8'($urandom));
    end else if (r < 16) begin
      send_start();
    end else if (r < 45) begin
      send_tick();
    end else begin
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        cmd = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
        send_rx(ID_HEARTBEAT + 11'(cur_node), cmd);
      end else if (sel < 8) begin
        case ($urandom_range(0, 4))
          0, 1:    cmd = CMD_ACK_INIT;
          2:       cmd = CMD_ACK_END;
          3:       cmd = CMD_ABORT;
          default: cmd = 8'($urandom);
        endcase
        send_rx(ID_SDO_RX + 11'(cur_node), cmd);
      end else begin
        send_rx(11'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [16:0] len;
    logic [15:0] tmo;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the part of the image that downloads read, plus the top address.
    calm = 1'b1;
    for (int a = 0; a < FILLED_BYTES; a++)
      send_beat(OP_LOAD, 16'(a), (a == 5) ? 8'hFF : 8'($urandom), 11'h7FF, 8'hFF);
    send_beat(OP_LOAD, 16'hFFFF, 8'hFF, 11'h0, 8'h0);
    calm = 1'b0;

    // Two full segments: the end frame reports no unused bytes; completes on a tick.
    set_config(7'd127, 17'd14, 16'd1000);
    open_block();
    send_rx(ID_SDO_RX + 11'(cur_node), CMD_ACK_END);
    send_rx(11'h123, 8'h55);
    send_tick();

    // A rejected first block stops the transfer.
    set_config(7'd1, 17'd10, 16'd2);
    open_block();
    send_rx(ID_SDO_RX + 11'(cur_node), CMD_ABORT);
    send_tick();

    // Two blocks: the second is rejected and rewound, then the timeout restarts.
    calm = 1'b1;
    set_config(7'd0, 17'd300, 16'd3);
    open_block();
    send_rx(ID_SDO_RX + 11'(cur_node), CMD_ACK_END);
    send_tick();
    send_rx(ID_SDO_RX + 11'(cur_node), CMD_ACK_INIT);
    send_rx(11'h123, 8'h55);
    send_rx(ID_SDO_RX + 11'(cur_node), CMD_ABORT);
    repeat (6) send_tick();
    calm = 1'b0;

    // Empty image: acknowledge with nothing left sends only an end frame.
    set_config(7'd64, 17'd0, 16'd0);
    send_start();
    send_rx(ID_HEARTBEAT + 11'(cur_node), 8'h00);
    send_rx(ID_SDO_RX + 11'(cur_node), CMD_ACK_INIT);
    send_tick();

    // Length beyond the store is clipped; only the first block is ever read.
    set_config(7'd42, 17'h1FFFF, 16'hFFFF);
    open_block();
    send_rx(ID_SDO_RX + 11'(cur_node), CMD_ABORT);

    // Random phases with varied settings.
    for (int p = 0; p < 16; p++) begin
      len = ($urandom_range(0, 9) < 7) ? 17'($urandom_range(0, 40))
                                       : 17'($urandom_range(0, FILLED_BYTES));
      case ($urandom_range(0, 4))
        0:       tmo = 16'd0;
        1:       tmo = 16'd1;
        2:       tmo = 16'($urandom_range(2, 20));
        3:       tmo = 16'hFFFF;
        default: tmo = 16'($urandom_range(1, 8));
      endcase
      set_config((p % 5 == 0) ? 7'd127 : 7'($urandom), len, tmo);
      calm = (p % 4 == 3);
      for (int i = 0; i < 10; i++) send_random();
      calm = 1'b0;
    end

    drain();
    if (errors == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/sdobdc_pkg.sv
rtl/core/sdobdc_ram.sv
rtl/core/sdobdc_queue.sv
rtl/core/sdobdc_front.sv
rtl/core/sdobdc_back.sv
rtl/core/sdo_block_download_client.sv
tb/sdo_block_download_client_checker.sv
tb/sdo_block_download_client_tb.sv
